FILE: sv/wmo_pkg.sv
package wmo_pkg;

  localparam int TABLE_SIZE_LOG2_DEF = 12;
  localparam int MAX_WAVES_DEF       = 8;
  localparam int QUEUE_DEPTH         = 2;

  localparam int PHASE_W     = 24;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [23:0] PHASE_INC_RESET = 24'd153791;
  localparam logic [15:0] AMP_GAIN_RESET  = 16'd6554;
  localparam logic [16:0] MORPH_RESET     = 17'd0;
  localparam logic [3:0]  WAVE_CNT_RESET  = 4'd1;
  localparam logic [23:0] INIT_PHASE_RESET = 24'd0;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_INC  = 3'd0,
    REG_AMP_GAIN   = 3'd1,
    REG_MORPH      = 3'd2,
    REG_WAVE_CNT   = 3'd3,
    REG_INIT_PHASE = 3'd4
  } reg_t;

  typedef struct packed {
    logic [15:0] amp_gain;
    logic [16:0] morph_position;
    logic [3:0]  wave_count;
  } cfg_t;

endpackage

FILE: sv/wmo_fifo.sv
module wmo_fifo import wmo_pkg::*; #(
  parameter int WIDTH = PHASE_W + 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] ent [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

FILE: sv/wmo_front.sv
module wmo_front import wmo_pkg::*; #(
  parameter int TABLE_SIZE_LOG2 = TABLE_SIZE_LOG2_DEF,
  parameter int MAX_WAVES       = MAX_WAVES_DEF,
  parameter int ENT_W           = PHASE_W + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  input  logic [2:0]             wave_select,
  input  logic [11:0]            table_address,
  input  logic signed [15:0]     table_value,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [ENT_W-1:0]       q_data
);

  localparam int WAVE_W = $clog2(MAX_WAVES);
  localparam int ADDR_W = WAVE_W + TABLE_SIZE_LOG2;
  localparam int PAY_W  = ENT_W - 1;

  logic [PHASE_W-1:0] phase_increment;
  logic [15:0]        amp_gain;
  logic [16:0]        morph_position;
  logic [3:0]         wave_count;
  logic [PHASE_W-1:0] initial_phase;
  logic [PHASE_W-1:0] phase;

  logic              accept;
  logic              wave_ok;
  logic [ADDR_W-1:0] wr_addr;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign wave_ok  = 32'(wave_select) < 32'(MAX_WAVES);
  assign wr_addr  = {WAVE_W'(wave_select), TABLE_SIZE_LOG2'(table_address)};

  assign cfg.amp_gain       = amp_gain;
  assign cfg.morph_position = morph_position;
  assign cfg.wave_count     = wave_count;

  always_comb begin
    q_push = 1'b0;
    q_data = {1'b0, PAY_W'(phase)};
    case (command)
      CMD_TICK: begin
        q_push = accept;
      end
      CMD_WRITE: begin
        q_push = accept && wave_ok;
        q_data = {1'b1, PAY_W'({wr_addr, table_value})};
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept && command == CMD_TICK) begin
      phase <= phase + phase_increment;
    end else if (accept && command == CMD_RESTART) begin
      phase <= initial_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= PHASE_INC_RESET;
      amp_gain        <= AMP_GAIN_RESET;
      morph_position  <= MORPH_RESET;
      wave_count      <= WAVE_CNT_RESET;
      initial_phase   <= INIT_PHASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_INC:  phase_increment <= cfg_data[23:0];
        REG_AMP_GAIN:   amp_gain        <= cfg_data[15:0];
        REG_MORPH:      morph_position  <= cfg_data[16:0];
        REG_WAVE_CNT:   wave_count      <= cfg_data[3:0];
        REG_INIT_PHASE: initial_phase   <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/wmo_back.sv
module wmo_back import wmo_pkg::*; #(
  parameter int TABLE_SIZE_LOG2 = TABLE_SIZE_LOG2_DEF,
  parameter int MAX_WAVES       = MAX_WAVES_DEF,
  parameter int ENT_W           = PHASE_W + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       q_empty,
  input  logic [ENT_W-1:0]           q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int WAVE_W = $clog2(MAX_WAVES);
  localparam int ADDR_W = WAVE_W + TABLE_SIZE_LOG2;
  localparam int DEPTH  = MAX_WAVES << TABLE_SIZE_LOG2;
  localparam int FRAC_L = PHASE_W - TABLE_SIZE_LOG2;
  localparam int CNT_W  = $clog2(MAX_WAVES + 1);
  localparam int CW     = (CNT_W > 4) ? CNT_W : 4;
  localparam int PR_W   = 17 + CW;
  localparam int MB_W   = (FRAC_L > 16) ? FRAC_L : 16;
  localparam int MP_W   = 18 + MB_W;
  localparam int SUM_W  = MP_W + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD1  = 4'd1;
  localparam logic [3:0] ST_RD2  = 4'd2;
  localparam logic [3:0] ST_RD3  = 4'd3;
  localparam logic [3:0] ST_RD4  = 4'd4;
  localparam logic [3:0] ST_BL2  = 4'd5;
  localparam logic [3:0] ST_INT  = 4'd6;
  localparam logic [3:0] ST_INT2 = 4'd7;
  localparam logic [3:0] ST_GAIN = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [15:0] mem [0:DEPTH-1];

  logic [3:0] state;

  // morph selection, refreshed every cycle from the register values
  logic [CW-1:0]     wc, cnt, cnt_m1, w1c;
  logic [16:0]       morph;
  logic [PR_W-1:0]   prod;
  logic [CW:0]       w1raw;
  logic [WAVE_W-1:0] w1_next, w2_next, w1_r, w2_r;
  logic [15:0]       frac_r;

  logic                      head_write;
  logic [PHASE_W-1:0]        head_phase, ph_reg, ph_use;
  logic [TABLE_SIZE_LOG2-1:0] pos, nxt;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic                      mem_we;
  logic signed [15:0]        rd_data;

  logic signed [15:0]     base, v1, v2, interp, sat;
  logic signed [16:0]     mul_a;
  logic [MB_W-1:0]        mul_b;
  logic signed [MP_W-1:0] mul_p, mult;
  logic signed [SUM_W-1:0] bsum, isum, gsum, bshift, ishift, gshift;
  logic                   load;

  always_comb begin
    wc = CW'(cfg.wave_count);
    if (wc == '0) begin
      cnt = CW'(1);
    end else if (wc > CW'(MAX_WAVES)) begin
      cnt = CW'(MAX_WAVES);
    end else begin
      cnt = wc;
    end
    cnt_m1 = cnt - CW'(1);
    morph  = (cfg.morph_position > 17'd65536) ? 17'd65536 : cfg.morph_position;
    prod   = PR_W'(morph) * PR_W'(cnt_m1);
    w1raw  = prod[PR_W-1:16];
    w1c    = (w1raw >= (CW + 1)'(cnt_m1)) ? cnt_m1 : CW'(w1raw);
    w1_next = WAVE_W'(w1c);
    w2_next = (w1c == cnt_m1) ? w1_next : WAVE_W'(w1c + CW'(1));
  end

  always_ff @(posedge clk) begin
    w1_r   <= w1_next;
    w2_r   <= w2_next;
    frac_r <= prod[15:0];
  end

  assign head_write = q_head[ENT_W-1];
  assign head_phase = q_head[PHASE_W-1:0];
  assign wr_addr    = q_head[ADDR_W+15:16];
  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign mem_we     = q_pop && head_write;

  assign ph_use = (state == ST_IDLE) ? head_phase : ph_reg;
  assign pos    = ph_use[PHASE_W-1:FRAC_L];
  assign nxt    = pos + 1'b1;

  always_comb begin
    case (state)
      ST_RD1:  rd_addr = {w2_r, pos};
      ST_RD2:  rd_addr = {w1_r, nxt};
      ST_RD3:  rd_addr = {w2_r, nxt};
      default: rd_addr = {w1_r, pos};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_head[15:0];
    end
    rd_data <= mem[rd_addr];
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      ST_RD2, ST_RD4: begin
        mul_a = 17'(rd_data) - 17'(base);
        mul_b = MB_W'(frac_r);
      end
      ST_INT: begin
        mul_a = 17'(v2) - 17'(v1);
        mul_b = MB_W'(ph_reg[FRAC_L-1:0]);
      end
      ST_GAIN: begin
        mul_a = 17'(interp);
        mul_b = MB_W'(cfg.amp_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mult = $signed(mul_a) * $signed({1'b0, mul_b});
  end

  always_comb begin
    bsum   = (SUM_W'(base) <<< 16) + SUM_W'(mul_p) + (SUM_W'(1) <<< 15);
    bshift = bsum >>> 16;
    isum   = (SUM_W'(v1) <<< FRAC_L) + SUM_W'(mul_p) + (SUM_W'(1) <<< (FRAC_L - 1));
    ishift = isum >>> FRAC_L;
    gsum   = SUM_W'(mul_p) + (SUM_W'(1) <<< 14);
    gshift = gsum >>> 15;
    if (gshift > SUM_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (gshift < SUM_W'(-32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = gshift[15:0];
    end
  end

  assign load = (state == ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: ph_reg <= head_phase;
      ST_RD1:  base   <= rd_data;
      ST_RD2:  mul_p  <= mult;
      ST_RD3: begin
        v1   <= bshift[15:0];
        base <= rd_data;
      end
      ST_RD4:  mul_p  <= mult;
      ST_BL2:  v2     <= bshift[15:0];
      ST_INT:  mul_p  <= mult;
      ST_INT2: interp <= ishift[15:0];
      ST_GAIN: mul_p  <= mult;
      default: begin
      end
    endcase
    if (load) begin
      sample <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop && !head_write) begin
            state <= ST_RD1;
          end
        end
        ST_RD1:  state <= ST_RD2;
        ST_RD2:  state <= ST_RD3;
        ST_RD3:  state <= ST_RD4;
        ST_RD4:  state <= ST_BL2;
        ST_BL2:  state <= ST_INT;
        ST_INT:  state <= ST_INT2;
        ST_INT2: state <= ST_GAIN;
        ST_GAIN: state <= ST_OUT;
        ST_OUT: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_wave_pair: assert property (@(posedge clk) disable iff (rst)
    (w2_r == w1_r) || (w2_r == WAVE_W'(w1_r + 1'b1)))
    else $error("morph neighbours not adjacent");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && !out_ready) |=> (state == ST_OUT && out_valid))
    else $error("pending sample overwritten");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> !($past(mem_we)) || $past(state) == ST_IDLE)
    else $error("store written during tick");

endmodule

FILE: sv/wavetable_morph_oscillator_core.sv
// tick path: queue, then back-end states IDLE, RD1-RD4, BL2, INT, INT2, GAIN, OUT
// ticks: the back-end sequencer ends one tick before it takes the next, doing four
// reads through the single store port and four passes through one multiplier
// table writes, restarts, unknown commands: one per cycle while ready, no result
// reset: phase 0, registers to defaults, queue and output empty; store not cleared
module wavetable_morph_oscillator_core import wmo_pkg::*; #(
  parameter int TABLE_SIZE_LOG2 = TABLE_SIZE_LOG2_DEF,
  parameter int MAX_WAVES       = MAX_WAVES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [2:0]                 wave_select,
  input  logic [11:0]                table_address,
  input  logic signed [15:0]         table_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int WAVE_W = $clog2(MAX_WAVES);
  localparam int ADDR_W = WAVE_W + TABLE_SIZE_LOG2;
  localparam int PAY_W  = (ADDR_W + 16 > PHASE_W) ? ADDR_W + 16 : PHASE_W;
  localparam int ENT_W  = PAY_W + 1;

  cfg_t             cfg;
  logic             q_full, q_push, q_pop, q_empty;
  logic [ENT_W-1:0] q_data, q_head;

  wmo_front #(
    .TABLE_SIZE_LOG2 (TABLE_SIZE_LOG2),
    .MAX_WAVES       (MAX_WAVES),
    .ENT_W           (ENT_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .wave_select   (wave_select),
    .table_address (table_address),
    .table_value   (table_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg           (cfg),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  wmo_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  wmo_back #(
    .TABLE_SIZE_LOG2 (TABLE_SIZE_LOG2),
    .MAX_WAVES       (MAX_WAVES),
    .ENT_W           (ENT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample)
  );

endmodule
